[hdl/sdmp_pkg.sv]
// Shared types and constants for the signed decimal magnitude parser.
// Used by the front classifier, the item queue, the parse engine and the top level.
package sdmp_pkg;

    localparam int SAMPLE_WIDTH = 31;
    localparam int INDEX_WIDTH  = 16;
    localparam int LIMIT_WIDTH  = 16;
    localparam int ACC_EXT_W    = SAMPLE_WIDTH + 4;

    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {SAMPLE_WIDTH{1'b1}};
    localparam logic [LIMIT_WIDTH-1:0]  LIMIT_RESET = LIMIT_WIDTH'(512);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IDX_SAMPLE_LIMIT = 1'b0;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        KIND_SPACE,
        KIND_DIGIT,
        KIND_SIGN,
        KIND_OTHER
    } char_kind_t;

    typedef struct packed {
        char_kind_t kind;
        logic [3:0] digit;
        logic       last;
    } item_t;

    typedef enum logic [1:0] {
        MODE_BETWEEN,
        MODE_SIGN,
        MODE_DIGITS,
        MODE_IGNORE
    } parse_mode_t;

endpackage

[hdl/sdmp_front.sv]
// Front part: classifies each incoming character and pushes it into the item queue.
// Depends on sdmp_pkg.
module sdmp_front
    import sdmp_pkg::*;
(
    input  logic       s_valid,
    input  logic [7:0] s_byte,
    input  logic       s_last,
    output logic       s_ready,
    output logic       push,
    output item_t      push_item,
    input  logic       queue_full
);

    char_kind_t kind;

    always_comb begin
        if (s_byte inside {[CHAR_ZERO:CHAR_NINE]}) begin
            kind = KIND_DIGIT;
        end else if (s_byte == CHAR_PLUS || s_byte == CHAR_MINUS) begin
            kind = KIND_SIGN;
        end else if (s_byte == CHAR_SPACE || s_byte inside {[CHAR_TAB:CHAR_CR]}) begin
            kind = KIND_SPACE;
        end else begin
            kind = KIND_OTHER;
        end
    end

    // ASCII digits carry their value in the low nibble.
    assign push_item.kind  = kind;
    assign push_item.digit = s_byte[3:0];
    assign push_item.last  = s_last;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

endmodule

[hdl/sdmp_queue.sv]
// Short queue of classified items between the front and the parse engine.
// Depends on sdmp_pkg.
module sdmp_queue
    import sdmp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    output logic  head_valid,
    output item_t head_item,
    input  logic  pop
);

    item_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   wr_ptr_reg;
    logic [QUEUE_AW:0]   rd_ptr_reg;

    assign full = (wr_ptr_reg[QUEUE_AW] != rd_ptr_reg[QUEUE_AW])
               && (wr_ptr_reg[QUEUE_AW-1:0] == rd_ptr_reg[QUEUE_AW-1:0]);
    assign head_valid = (wr_ptr_reg != rd_ptr_reg);
    assign head_item  = entry_reg[rd_ptr_reg[QUEUE_AW-1:0]];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg[QUEUE_AW-1:0]] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg - rd_ptr_reg) <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue fill level exceeds its depth");

endmodule

[hdl/sdmp_back.sv]
// Parse engine: runs the number state machine over classified items and holds
// the result in an output register. Depends on sdmp_pkg.
module sdmp_back
    import sdmp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    head_valid,
    input  item_t                   head_item,
    output logic                    pop,
    input  logic [LIMIT_WIDTH-1:0]  sample_limit,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [SAMPLE_WIDTH-1:0] m_sample,
    output logic [INDEX_WIDTH-1:0]  m_index
);

    parse_mode_t              mode_reg, mode_next;
    logic [SAMPLE_WIDTH-1:0]  acc_reg, acc_next;
    logic [INDEX_WIDTH-1:0]   count_reg, count_next;
    logic                     out_valid_reg;
    logic [SAMPLE_WIDTH-1:0]  out_sample_reg;
    logic [INDEX_WIDTH-1:0]   out_index_reg;

    logic [ACC_EXT_W-1:0]     acc_times_ten;
    logic [SAMPLE_WIDTH-1:0]  acc_grown;
    logic                     finish;
    logic [SAMPLE_WIDTH-1:0]  finish_value;
    logic                     emit;

    assign pop = head_valid && (!out_valid_reg || m_ready);

    // Multiply by ten as two shifts, add the digit, then saturate.
    always_comb begin
        acc_times_ten = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                      + {{(ACC_EXT_W-4){1'b0}}, head_item.digit};
        if (acc_times_ten > {4'b0000, SAMPLE_MAX}) begin
            acc_grown = SAMPLE_MAX;
        end else begin
            acc_grown = acc_times_ten[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb begin
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        count_next   = count_reg;
        finish       = 1'b0;
        finish_value = acc_reg;

        case (mode_reg)
            MODE_BETWEEN: begin
                case (head_item.kind)
                    KIND_DIGIT: begin
                        acc_next  = {{(SAMPLE_WIDTH-4){1'b0}}, head_item.digit};
                        mode_next = MODE_DIGITS;
                    end
                    KIND_SIGN: begin
                        acc_next  = '0;
                        mode_next = MODE_SIGN;
                    end
                    KIND_OTHER: mode_next = MODE_IGNORE;
                    default:    mode_next = MODE_BETWEEN;
                endcase
            end
            MODE_SIGN: begin
                if (head_item.kind == KIND_DIGIT) begin
                    acc_next  = {{(SAMPLE_WIDTH-4){1'b0}}, head_item.digit};
                    mode_next = MODE_DIGITS;
                end else begin
                    acc_next  = '0;
                    mode_next = MODE_IGNORE;
                end
            end
            MODE_DIGITS: begin
                if (head_item.kind == KIND_DIGIT) begin
                    acc_next = acc_grown;
                end else begin
                    finish   = 1'b1;
                    acc_next = '0;
                    case (head_item.kind)
                        KIND_SPACE: mode_next = MODE_BETWEEN;
                        KIND_SIGN:  mode_next = MODE_SIGN;
                        default:    mode_next = MODE_IGNORE;
                    endcase
                end
            end
            default: mode_next = mode_reg;
        endcase

        // The end of a line finishes a number still in its digits.
        if (head_item.last && mode_next == MODE_DIGITS) begin
            finish       = 1'b1;
            finish_value = acc_next;
        end

        emit = finish && (finish_value != '0) && (count_reg < sample_limit);

        if (emit) begin
            count_next = count_reg + 1'b1;
        end
        if (head_item.last) begin
            acc_next   = '0;
            mode_next  = MODE_BETWEEN;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_BETWEEN;
            acc_reg   <= '0;
            count_reg <= '0;
        end else if (pop) begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            out_sample_reg <= finish_value;
            out_index_reg  <= count_reg;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_sample = out_sample_reg;
    assign m_index  = out_index_reg;

    a_no_zero_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample != '0))
        else $error("zero sample presented on the output");

    a_acc_only_in_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_DIGITS) |-> (acc_reg == '0))
        else $error("accumulator holds a value outside a number");

    a_line_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_item.last) |=> (mode_reg == MODE_BETWEEN && count_reg == '0))
        else $error("line state not cleared after the end of a line");

endmodule

[hdl/signed_decimal_magnitude_parser.sv]
// Top level of the signed decimal magnitude parser: stream ports, APB register,
// front classifier, item queue and parse engine. Depends on sdmp_pkg and submodules.
// A result is registered on m_tvalid when the parse engine pops the item ending its
// number. Throughput: one byte per cycle while the item queue is not full; the parse
// engine's multiply-by-ten and add step retires one queued item per cycle while the
// output register can take a result. Reset: synchronous, active low; clears the
// queue, line state and output, and sets the per-line sample limit to 512.
module signed_decimal_magnitude_parser
    import sdmp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // last_of_line
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,   // [30:0] sample, [46:31] sample_index, [47] zero
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [LIMIT_WIDTH-1:0]  sample_limit_reg;
    logic                    push;
    item_t                   push_item;
    logic                    queue_full;
    logic                    head_valid;
    item_t                   head_item;
    logic                    pop;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic [INDEX_WIDTH-1:0]  sample_index;
    logic                    reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_IDX_SAMPLE_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            sample_limit_reg <= pwdata[LIMIT_WIDTH-1:0];
        end
    end

    assign prdata = reg_sel ? {{(PDATA_W-LIMIT_WIDTH){1'b0}}, sample_limit_reg} : '0;

    sdmp_front u_front (
        .s_valid    (s_tvalid),
        .s_byte     (s_tdata),
        .s_last     (s_tlast),
        .s_ready    (s_tready),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    sdmp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    sdmp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .sample_limit (sample_limit_reg),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_sample     (sample),
        .m_index      (sample_index)
    );

    assign m_tdata = {1'b0, sample_index, sample};

endmodule

[tb/signed_decimal_magnitude_parser_tb.sv]
// Self-checking testbench for signed_decimal_magnitude_parser: streams text lines, predicts
// each parsed magnitude and its index within the line, and checks every result transaction.
// Depends on sdmp_pkg and the parser RTL only.
module signed_decimal_magnitude_parser_tb
    import sdmp_pkg::*;
;

    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int STALL_LIMIT    = 4000;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_BYTES    = 136;
    localparam logic [PADDR_W-1:0] ADDR_SAMPLE_LIMIT = PADDR_W'(4 * REG_IDX_SAMPLE_LIMIT);
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } line_byte_t;

    typedef struct {
        logic [SAMPLE_WIDTH-1:0] sample;
        logic [INDEX_WIDTH-1:0]  index;
    } sample_rec_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;   // [7:0] data_byte
    logic               s_tlast = 1'b0; // last_of_line
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [47:0]        m_tdata;        // [30:0] sample, [46:31] sample_index, [47] zero
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    signed_decimal_magnitude_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Parser state as the testbench sees it.
    logic [SAMPLE_WIDTH-1:0] number_acc = '0;
    parse_mode_t             line_mode = MODE_BETWEEN;
    logic [INDEX_WIDTH-1:0]  line_count = '0;
    logic [LIMIT_WIDTH-1:0]  line_limit = LIMIT_RESET;

    line_byte_t  pending_bytes[$];
    line_byte_t  line_buf[$];
    sample_rec_t expected_samples[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_armed = 1'b0;
    int          hold_left = 0;
    int          idle_cycles = 0;

    int error_count = 0;
    int bytes_accepted = 0;
    int samples_checked = 0;
    int lines_queued = 0;
    int phase_bytes = 0;

    line_byte_t  next_byte;
    sample_rec_t want;
    logic [SAMPLE_WIDTH-1:0] got_sample;
    logic [INDEX_WIDTH-1:0]  got_index;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Emits the finished number if it is nonzero and the line still has room.
    function automatic void close_number();
        sample_rec_t rec;
        if (number_acc != '0 && line_count < line_limit) begin
            rec.sample = number_acc;
            rec.index  = line_count;
            expected_samples.push_back(rec);
            line_count = line_count + 1'b1;
        end
        number_acc = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] c, input logic last);
        logic        is_digit;
        logic        is_sign;
        logic        is_space;
        logic [63:0] d;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        is_sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
        is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
        d = 64'(c - CHAR_ZERO);
        case (line_mode)
            MODE_BETWEEN: begin
                if (is_digit) begin
                    number_acc = SAMPLE_WIDTH'(d);
                    line_mode = MODE_DIGITS;
                end else if (is_sign) begin
                    number_acc = '0;
                    line_mode = MODE_SIGN;
                end else if (!is_space) begin
                    line_mode = MODE_IGNORE;
                end
            end
            MODE_SIGN: begin
                if (is_digit) begin
                    number_acc = SAMPLE_WIDTH'(d);
                    line_mode = MODE_DIGITS;
                end else begin
                    number_acc = '0;
                    line_mode = MODE_IGNORE;
                end
            end
            MODE_DIGITS: begin
                if (is_digit) begin
                    // Saturate before the multiply-add would pass the largest sample.
                    if (64'(number_acc) > (64'(SAMPLE_MAX) - d) / 10)
                        number_acc = SAMPLE_MAX;
                    else
                        number_acc = SAMPLE_WIDTH'(64'(number_acc) * 10 + d);
                end else begin
                    close_number();
                    if (is_space)
                        line_mode = MODE_BETWEEN;
                    else if (is_sign)
                        line_mode = MODE_SIGN;
                    else
                        line_mode = MODE_IGNORE;
                end
            end
            default: ;
        endcase
        if (last) begin
            if (line_mode == MODE_DIGITS)
                close_number();
            number_acc = '0;
            line_mode = MODE_BETWEEN;
            line_count = '0;
        end
    endfunction

    // Input side: predicts on every accepted transaction and offers the next byte.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_byte = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_byte.ch;
                    s_tlast  <= next_byte.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side backpressure, with an optional long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_armed) begin
            hold_armed <= 1'b0;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_sample = m_tdata[SAMPLE_WIDTH-1:0];
            got_index  = m_tdata[SAMPLE_WIDTH +: INDEX_WIDTH];
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected result, got sample %0d index %0d",
                         $time, got_sample, got_index);
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                if (got_sample != want.sample || got_index != want.index) begin
                    $display("%0t: result mismatch, expected sample %0d index %0d, got %0d %0d",
                             $time, want.sample, want.index, got_sample, got_index);
                    error_count++;
                end
                samples_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_char(input logic [7:0] c);
        line_byte_t b;
        b.ch = c;
        b.last = 1'b0;
        line_buf.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    task automatic add_space();
        int r;
        r = $urandom_range(9);
        if (r < 5)
            add_char(CHAR_SPACE);
        else if (r == 5)
            add_char(CHAR_TAB);
        else if (r == 6)
            add_char(CHAR_LF);
        else
            add_char(CHAR_TAB + 8'($urandom_range(2, 4)));
    endtask

    // Digits of one number: mostly short, some long enough to saturate, some zero.
    task automatic add_digits();
        int r;
        int nd;
        r = $urandom_range(99);
        if (r < 3) begin
            add_text($urandom_range(1) ? "2147483647" : "2147483648");
        end else if (r < 12) begin
            nd = $urandom_range(1, 4);
            repeat (nd) add_char(CHAR_ZERO);
        end else begin
            if (r < 70)
                nd = $urandom_range(1, 4);
            else if (r < 88)
                nd = $urandom_range(5, 9);
            else
                nd = $urandom_range(10, 13);
            repeat (nd) add_char(CHAR_ZERO + 8'($urandom_range(9)));
        end
    endtask

    task automatic add_numbers(input int count);
        int r;
        for (int t = 0; t < count; t++) begin
            r = $urandom_range(99);
            if (t > 0 && !(r < 40 && $urandom_range(2) == 0))
                repeat ($urandom_range(1, 2)) add_space();
            if (r < 25)
                add_char(CHAR_MINUS);
            else if (r < 40)
                add_char(CHAR_PLUS);
            add_digits();
        end
    endtask

    // Marks the end of the line and hands it to the driver.
    task automatic commit_line();
        line_byte_t b;
        b = line_buf.pop_back();
        b.last = 1'b1;
        line_buf.push_back(b);
        phase_bytes += line_buf.size();
        lines_queued++;
        while (line_buf.size() > 0)
            pending_bytes.push_back(line_buf.pop_front());
    endtask

    task automatic add_random_line();
        int kind;
        int pos;
        line_byte_t bad;
        kind = $urandom_range(99);
        if (kind < 85) begin
            if ($urandom_range(3) == 0)
                add_space();
            add_numbers($urandom_range(1, 8));
            if ($urandom_range(1))
                add_space();
            if (kind >= 70) begin
                // Corrupt a well-formed line with a stray character or a bare sign.
                pos = $urandom_range(line_buf.size());
                bad.last = 1'b0;
                case ($urandom_range(4))
                    0: bad.ch = "x";
                    1: bad.ch = ".";
                    2: bad.ch = CHAR_NUL;
                    3: bad.ch = 8'($urandom_range(255));
                    default: begin
                        bad.ch = CHAR_SPACE;
                        line_buf.insert(pos, bad);
                        bad.ch = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
                    end
                endcase
                line_buf.insert(pos, bad);
            end
        end else begin
            repeat ($urandom_range(1, 10)) add_char(8'($urandom_range(255)));
        end
        commit_line();
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_samples.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_sample_limit(input logic [LIMIT_WIDTH-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SAMPLE_LIMIT;
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        line_limit = value;
        @(posedge aclk);
        psel    <= 1'b1;
        paddr   <= ADDR_SAMPLE_LIMIT;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (prdata != PDATA_W'(value)) begin
            $display("%0t: limit readback mismatch, expected %0d, got %0d",
                     $time, value, prdata);
            error_count++;
        end
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [LIMIT_WIDTH-1:0] limit_val;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed lines: saturation on a negative number, a dropped zero, a sign that
        // ends a number, a sign with no digits, a NUL after digits and a stray character.
        add_text("-2147483648 +0 12+3");
        commit_line();
        add_text("+-9");
        commit_line();
        add_text("8");
        add_char(CHAR_NUL);
        add_text(" 5");
        commit_line();
        add_text(" z1");
        commit_line();
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                1: limit_val = 16'hFFFF;
                2: limit_val = 16'd1;
                3: limit_val = 16'd3;
                4: limit_val = 16'd0;
                5: limit_val = LIMIT_WIDTH'($urandom_range(4, 9));
                6: limit_val = 16'd2;
                7: limit_val = LIMIT_WIDTH'($urandom_range(1, 8));
                default: limit_val = LIMIT_RESET;
            endcase
            if (p > 0)
                write_sample_limit(limit_val);
            case (p % 4)
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                3: begin send_idle_pct = 33; recv_stall_pct = 33; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES / 2)
                add_random_line();
            if (p == 0)
                hold_armed = 1'b1;  // sender keeps offering while results back up
            if (p == 3)
                wait_drained();
            while (phase_bytes < PHASE_BYTES)
                add_random_line();
            wait_drained();
        end

        $display("Parsed %0d bytes in %0d lines and checked %0d samples,", bytes_accepted,
                 lines_queued, samples_checked);
        $display("over sample limits from 0 to 65535 and four backpressure patterns.");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/sdmp_pkg.sv
hdl/sdmp_front.sv
hdl/sdmp_queue.sv
hdl/sdmp_back.sv
hdl/signed_decimal_magnitude_parser.sv
tb/signed_decimal_magnitude_parser_tb.sv
